@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RCC_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define RCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define RCC_ASSERT(lbl, clk, rstn, expr)
`define RCC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/rcc_pkg.sv @@
`default_nettype none
package rcc_pkg;

  localparam int KERNEL_H_DEF = 5;
  localparam int KERNEL_W_DEF = 5;
  localparam int MAX_LINE_DEF = 2048;

  localparam int SAMPLE_W     = 8;
  localparam int NUM_CH       = 3;
  localparam int COEF_W       = 16;
  localparam int IDX_W        = 5;
  localparam int SRC_WIDTH_W  = 12;
  localparam int OUT_HEIGHT_W = 13;
  localparam int ROW_W        = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int QUEUE_DEPTH  = 8;
  localparam int HEIGHT_CAP   = 4096;

  localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RST  = 12'd2048;
  localparam logic [OUT_HEIGHT_W-1:0] OUT_HEIGHT_RST = 13'd1;
  localparam logic [SAMPLE_W-1:0]     CLAMP_MAX      = 8'd255;

  localparam logic KIND_COEF  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'd1;

  // channel 0 red, 1 green, 2 blue
  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] pixel_t;

  typedef struct packed {
    logic                     valid;
    logic                     is_coef;
    logic                     produce;
    logic                     last;
    logic [IDX_W-1:0]         coef_index;
    logic [COEF_W-1:0]        coef_value;
    pixel_t                   pix;
  } front_op_t;

  typedef struct packed {
    logic   frame_last;
    pixel_t pix;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/rcc_if.sv @@
`default_nettype none
interface rcc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [rcc_pkg::IDX_W-1:0]           coef_index;
  logic signed [rcc_pkg::COEF_W-1:0]   coef_value;
  logic [rcc_pkg::SAMPLE_W-1:0]        red;
  logic [rcc_pkg::SAMPLE_W-1:0]        green;
  logic [rcc_pkg::SAMPLE_W-1:0]        blue;

  modport source (output valid, kind, coef_index, coef_value, red, green, blue,
                  input ready);
  modport sink   (input valid, kind, coef_index, coef_value, red, green, blue,
                  output ready);
endinterface

interface rcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [rcc_pkg::SAMPLE_W-1:0] out_red;
  logic [rcc_pkg::SAMPLE_W-1:0] out_green;
  logic [rcc_pkg::SAMPLE_W-1:0] out_blue;
  logic                         frame_last;

  modport source (output valid, out_red, out_green, out_blue, frame_last,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/rgb_conv2d_clamp.sv @@
`default_nettype none
// rgb 2-d convolution with clamp: requests of kind 0 load one 16-bit kernel
// coefficient, requests of kind 1 are raster pixels of the border-extended
// source; each complete window yields one clamped rgb pixel, the last of a
// frame flagged. one request is taken per clock: line buffers read one
// column of every stored row per request, the multiply and adder tree are
// fully parallel and pipelined, so the sustained rate is one request a cycle;
// a result passes the request register, window, product and row-sum
// registers before it is written to the result queue. input ready drops only
// when the eight-entry result queue plus results in flight would overflow.
// line buffers need no clearing pass; kernel and window start at zero.
module rgb_conv2d_clamp #(
  parameter int KERNEL_H = rcc_pkg::KERNEL_H_DEF,
  parameter int KERNEL_W = rcc_pkg::KERNEL_W_DEF,
  parameter int MAX_LINE = rcc_pkg::MAX_LINE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rcc_in_if.sink                              in_ch,
  rcc_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [rcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rcc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcc_pkg::*;

  localparam int SLOT_W = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
  localparam int COL_W  = $clog2(MAX_LINE);

  // front to back: classified request plus line buffer access
  front_op_t         op;
  logic [SLOT_W-1:0] op_slot, lb_wslot;
  logic [COL_W-1:0]  lb_addr;
  logic              lb_we;
  pixel_t            lb_wdata;

  // back to result queue
  logic              push;
  result_t           push_data;
  logic              out_pop;

  assign out_pop = out_ch.valid && out_ch.ready;

  rcc_front #(
    .KH(KERNEL_H), .KW(KERNEL_W), .ML(MAX_LINE), .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_pop  (out_pop),
    .op       (op),
    .op_slot  (op_slot),
    .lb_addr  (lb_addr),
    .lb_we    (lb_we),
    .lb_wslot (lb_wslot),
    .lb_wdata (lb_wdata)
  );

  // window, kernel store and multiply-accumulate pipeline
  rcc_back #(
    .KH(KERNEL_H), .KW(KERNEL_W), .ML(MAX_LINE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .op_slot  (op_slot),
    .lb_addr  (lb_addr),
    .lb_we    (lb_we),
    .lb_wslot (lb_wslot),
    .lb_wdata (lb_wdata),
    .push     (push),
    .push_data(push_data)
  );

  // result queue decouples the sink from the pipeline
  rcc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .out_ch   (out_ch)
  );
endmodule
`default_nettype wire

@@ hdl/rcc_ram.sv @@
`default_nettype none
module rcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/rcc_front.sv @@
`default_nettype none
`include "assert_macros.svh"
module rcc_front #(
  parameter int KH    = 5,
  parameter int KW    = 5,
  parameter int ML    = 2048,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  rcc_in_if.sink                                      in_ch,
  input  wire logic                                   cfg_we,
  input  wire logic [rcc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [rcc_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                                   out_pop,
  output rcc_pkg::front_op_t                          op,
  output logic [((KH > 1) ? $clog2(KH) : 1)-1:0]      op_slot,
  output logic [$clog2(ML)-1:0]                       lb_addr,
  output logic                                        lb_we,
  output logic [((KH > 1) ? $clog2(KH) : 1)-1:0]      lb_wslot,
  output rcc_pkg::pixel_t                             lb_wdata
);
  import rcc_pkg::*;

  localparam int COL_W  = $clog2(ML);
  localparam int SLOT_W = (KH > 1) ? $clog2(KH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = 16;

  logic [SRC_WIDTH_W-1:0]  src_width_r;
  logic [OUT_HEIGHT_W-1:0] out_height_r;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  front_op_t               op_r, op_nxt;
  logic [SLOT_W-1:0]       op_slot_r;

  logic [CMP_W-1:0] eff_w, height, rows_total, c, r;
  logic             produce, last, in_fire, pix_fire;
  pixel_t           pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      out_height_r <= OUT_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SRC_WIDTH_W-1:0];
        CFG_OUT_HEIGHT: out_height_r <= cfg_data[OUT_HEIGHT_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    // effective geometry
    if (CMP_W'(src_width_r) > CMP_W'(ML)) begin
      eff_w = CMP_W'(ML);
    end else if (src_width_r == '0) begin
      eff_w = CMP_W'(1);
    end else begin
      eff_w = CMP_W'(src_width_r);
    end
    height = (CMP_W'(out_height_r) > CMP_W'(HEIGHT_CAP)) ? CMP_W'(HEIGHT_CAP)
                                                        : CMP_W'(out_height_r);
    rows_total = height + CMP_W'(KH - 1);
    c = CMP_W'(col_r);
    r = CMP_W'(row_r);

    produce = (c < eff_w) && (r < rows_total) && (c >= CMP_W'(KW - 1)) &&
              (r >= CMP_W'(KH - 1)) && (eff_w >= CMP_W'(KW));
    last    = (r == rows_total - CMP_W'(1)) && (c == eff_w - CMP_W'(1));

    in_ready_calc: begin
    end
    in_fire  = in_ch.valid && in_ch.ready;
    pix_fire = in_fire && (in_ch.kind == KIND_PIXEL);
    pix      = {in_ch.blue, in_ch.green, in_ch.red};

    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (pix_fire) begin
      if (c + CMP_W'(1) >= eff_w) begin
        col_nxt = '0;
        if (r + CMP_W'(1) >= rows_total) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = ROW_W'(r + CMP_W'(1));
          slot_nxt = (slot_r == SLOT_W'(KH - 1)) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        col_nxt = COL_W'(c + CMP_W'(1));
      end
    end

    cnt_nxt = cnt_r + CNT_W'(pix_fire && produce) - CNT_W'(out_pop);

    op_nxt.valid      = in_fire;
    op_nxt.is_coef    = (in_ch.kind == KIND_COEF);
    op_nxt.produce    = pix_fire && produce;
    op_nxt.last       = last;
    op_nxt.coef_index = in_ch.coef_index;
    op_nxt.coef_value = in_ch.coef_value;
    op_nxt.pix        = pix;
  end

  // credit covers pipeline plus result queue
  assign in_ch.ready = (cnt_r < CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      slot_r   <= '0;
      cnt_r    <= '0;
      op_r     <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      slot_r   <= slot_nxt;
      cnt_r    <= cnt_nxt;
      op_r     <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_slot_r <= slot_r;
  end

  assign op       = op_r;
  assign op_slot  = op_slot_r;
  assign lb_addr  = col_r;
  assign lb_we    = pix_fire;
  assign lb_wslot = slot_r;
  assign lb_wdata = pix;

  `RCC_ASSERT(a_col_in_line, clk, rst_n, CMP_W'(col_r) < CMP_W'(ML))
  `RCC_ASSERT(a_credit_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH))
endmodule
`default_nettype wire

@@ hdl/rcc_back.sv @@
`default_nettype none
module rcc_back #(
  parameter int KH = 5,
  parameter int KW = 5,
  parameter int ML = 2048
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  rcc_pkg::front_op_t                     op,
  input  wire logic [((KH > 1) ? $clog2(KH) : 1)-1:0] op_slot,
  input  wire logic [$clog2(ML)-1:0]             lb_addr,
  input  wire logic                              lb_we,
  input  wire logic [((KH > 1) ? $clog2(KH) : 1)-1:0] lb_wslot,
  input  rcc_pkg::pixel_t                        lb_wdata,
  output logic                                   push,
  output rcc_pkg::result_t                       push_data
);
  import rcc_pkg::*;

  localparam int SLOT_W = (KH > 1) ? $clog2(KH) : 1;
  localparam int TAPS   = KH * KW;
  localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PIX_W  = NUM_CH * SAMPLE_W;

  logic [PIX_W-1:0] rd_data [KH];
  pixel_t           column [KH];
  pixel_t           win_r [KH][KW];
  front_op_t        s2_r;
  logic [COEF_W-1:0] coef_r [TAPS];
  logic [COEF_W-1:0] prod_r [KH][KW][NUM_CH];
  logic [COEF_W-1:0] rowsum_r [KH][NUM_CH];
  logic [COEF_W-1:0] total [NUM_CH];
  logic              s3_prod_r, s3_last_r, s4_prod_r, s4_last_r;

  for (genvar k = 0; k < KH; k++) begin : g_line
    rcc_ram #(.WIDTH(PIX_W), .DEPTH(ML)) u_line (
      .clk  (clk),
      .we   (lb_we && (lb_wslot == SLOT_W'(k))),
      .waddr(lb_addr),
      .wdata(lb_wdata),
      .raddr(lb_addr),
      .rdata(rd_data[k])
    );
  end

  // window column, oldest row first; newest row comes from the request itself
  always_comb begin
    int s;
    for (int dy = 0; dy < KH; dy++) begin
      s = int'(op_slot) + 1 + dy;
      if (s >= KH) s = s - KH;
      if (dy == KH - 1) begin
        column[dy] = op.pix;
      end else begin
        column[dy] = rd_data[SLOT_W'(s)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int dy = 0; dy < KH; dy++) begin
        for (int dx = 0; dx < KW; dx++) begin
          win_r[dy][dx] <= '0;
        end
      end
    end else if (op.valid && !op.is_coef) begin
      for (int dy = 0; dy < KH; dy++) begin
        for (int dx = 0; dx < KW - 1; dx++) begin
          win_r[dy][dx] <= win_r[dy][dx+1];
        end
        win_r[dy][KW-1] <= column[dy];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r      <= '0;
      s3_prod_r <= 1'b0;
      s4_prod_r <= 1'b0;
      for (int t = 0; t < TAPS; t++) coef_r[t] <= '0;
    end else begin
      s2_r      <= op;
      s3_prod_r <= s2_r.valid && s2_r.produce;
      s4_prod_r <= s3_prod_r;
      if (s2_r.valid && s2_r.is_coef && (int'(s2_r.coef_index) < TAPS)) begin
        coef_r[TAP_W'(s2_r.coef_index)] <= s2_r.coef_value;
      end
    end
  end

  // products, transposed kernel, wrapping at 16 bits
  always_ff @(posedge clk) begin
    s3_last_r <= s2_r.last;
    for (int dy = 0; dy < KH; dy++) begin
      for (int dx = 0; dx < KW; dx++) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (dx * KW + dy < TAPS) begin
            prod_r[dy][dx][ch] <= coef_r[TAP_W'(dx * KW + dy)] *
                                  {{(COEF_W-SAMPLE_W){1'b0}}, win_r[dy][dx][ch]};
          end else begin
            prod_r[dy][dx][ch] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [COEF_W-1:0] acc;
    s4_last_r <= s3_last_r;
    for (int dy = 0; dy < KH; dy++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        acc = '0;
        for (int dx = 0; dx < KW; dx++) acc = acc + prod_r[dy][dx][ch];
        rowsum_r[dy][ch] <= acc;
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] clamp(input logic [COEF_W-1:0] v);
    if (v[COEF_W-1]) return '0;
    else if (v > COEF_W'(CLAMP_MAX)) return CLAMP_MAX;
    else return v[SAMPLE_W-1:0];
  endfunction

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      total[ch] = '0;
      for (int dy = 0; dy < KH; dy++) total[ch] = total[ch] + rowsum_r[dy][ch];
      push_data.pix[ch] = clamp(total[ch]);
    end
    push_data.frame_last = s4_last_r;
  end

  assign push = s4_prod_r;
endmodule
`default_nettype wire

@@ hdl/rcc_queue.sv @@
`default_nettype none
`include "assert_macros.svh"
module rcc_queue #(
  parameter int DEPTH = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  rcc_pkg::result_t push_data,
  rcc_out_if.source       out_ch
);
  import rcc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;
  result_t          head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign out_ch.valid      = (count_r != '0);
  assign out_ch.out_red    = head.pix[0];
  assign out_ch.out_green  = head.pix[1];
  assign out_ch.out_blue   = head.pix[2];
  assign out_ch.frame_last = head.frame_last;

  `RCC_ASSERT_IMP(a_no_overflow, clk, rst_n, push, count_r < CNT_W'(DEPTH))
endmodule
`default_nettype wire
